// File: sv/assert_macros.svh
// Assertion macros for the checker file.
// Each macro takes a label, a property body and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define PQE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PQE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/pqe_pkg.sv
package pqe_pkg;

  localparam int JOB_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 5;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  // Control states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [PRIO_W-1:0] prio;
    logic [JOB_W-1:0]  job;
  } token_t;

endpackage

// File: sv/pqe_cell.sv
module pqe_cell #(
  parameter int DEPTH    = 16,
  parameter int CELL_IDX = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  logic                              ins_i,
  input  logic [pqe_pkg::JOB_W-1:0]         ins_job_i,
  input  logic [pqe_pkg::PRIO_W-1:0]        ins_prio_i,
  input  logic                              shift_i,
  input  logic [$clog2(DEPTH)-1:0]          best_idx_i,
  input  logic [pqe_pkg::JOB_W-1:0]         nxt_job_i,
  input  logic [pqe_pkg::PRIO_W-1:0]        nxt_prio_i,
  input  pqe_pkg::token_t                   tok_i,
  input  logic [$clog2(DEPTH)-1:0]          tok_idx_i,
  output pqe_pkg::token_t                   tok_o,
  output logic [$clog2(DEPTH)-1:0]          tok_idx_o,
  output logic [pqe_pkg::JOB_W-1:0]         job_o,
  output logic [pqe_pkg::PRIO_W-1:0]        prio_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [pqe_pkg::JOB_W-1:0]  job_q, job_d;
  logic [pqe_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic                       tok_vld_q;
  logic                       tok_hit_q, tok_hit_d;
  logic [pqe_pkg::PRIO_W-1:0] tok_prio_q, tok_prio_d;
  logic [pqe_pkg::JOB_W-1:0]  tok_job_q, tok_job_d;
  logic [IDX_W-1:0]           tok_idx_q, tok_idx_d;
  logic                       occupied;
  logic                       take;

  assign occupied = count_i > CNT_W'(CELL_IDX);

  // Strictly greater, so the earlier arrival keeps a tie.
  assign take = tok_i.vld && occupied && (!tok_i.hit || (prio_q > tok_i.prio));

  always_comb begin
    job_d  = job_q;
    prio_d = prio_q;
    if (ins_i && (count_i == CNT_W'(CELL_IDX))) begin
      job_d  = ins_job_i;
      prio_d = ins_prio_i;
    end else if (shift_i && (IDX_W'(CELL_IDX) >= best_idx_i)) begin
      job_d  = nxt_job_i;
      prio_d = nxt_prio_i;
    end
  end

  always_comb begin
    tok_hit_d  = tok_i.hit;
    tok_prio_d = tok_i.prio;
    tok_job_d  = tok_i.job;
    tok_idx_d  = tok_idx_i;
    if (take) begin
      tok_hit_d  = 1'b1;
      tok_prio_d = prio_q;
      tok_job_d  = job_q;
      tok_idx_d  = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    prio_q     <= prio_d;
    tok_hit_q  <= tok_hit_d;
    tok_prio_q <= tok_prio_d;
    tok_job_q  <= tok_job_d;
    tok_idx_q  <= tok_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
    end
  end

  assign tok_o.vld  = tok_vld_q;
  assign tok_o.hit  = tok_hit_q;
  assign tok_o.prio = tok_prio_q;
  assign tok_o.job  = tok_job_q;
  assign tok_idx_o  = tok_idx_q;
  assign job_o      = job_q;
  assign prio_o     = prio_q;

endmodule

// File: sv/priority_queue_extract_max.sv
// Channel   Direction  Handshake                      Payload
// request   in         start high while busy is low   kind_i, job_id_i, priority_req_i
// result    out        done_o high for one cycle      job_out_o, found_o, accepted_o,
//                                                     count_o, is_full_o, is_empty_o
//
// An insert, a clear, an unused code or an extract on an empty queue gives its
// result in the cycle after the request is taken, and busy stays low.
// An extract on a non-empty queue keeps busy high until its result, which waits
// for the search token walking the row of DEPTH cells one cell per cycle.
// Reset is asynchronous and active low; it empties the queue and stops any search.
// The receiver cannot stall: every result is shown for exactly one cycle.
module priority_queue_extract_max #(
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic [pqe_pkg::JOB_W-1:0]    job_id_i,
  input  logic [pqe_pkg::PRIO_W-1:0]   priority_req_i,
  output logic                         done_o,
  output logic [pqe_pkg::JOB_W-1:0]    job_out_o,
  output logic                         found_o,
  output logic                         accepted_o,
  output logic [pqe_pkg::COUNT_W-1:0]  count_o,
  output logic                         is_full_o,
  output logic                         is_empty_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // The queue lives in a row of cells in arrival order: cell 0 holds the oldest
  // entry. An insert writes the cell at the current count. An extract launches a
  // search token into cell 0; each cell replaces the token's best entry with its
  // own when it is occupied and strictly higher in priority, so the earliest of
  // equal priorities survives. When the token leaves the last cell, every cell at
  // or above the winner's place takes its right neighbour's entry, all in the same cycle.

  pqe_pkg::state_e             state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        done_q, done_d;
  logic [pqe_pkg::JOB_W-1:0]   job_q, job_d;
  logic                        found_q, found_d;
  logic                        acc_q, acc_d;

  logic                        take_req;
  logic                        launch;
  logic                        finish;
  logic                        ins_en;
  logic                        queue_empty;
  logic                        queue_full;

  pqe_pkg::token_t             launch_tok;
  pqe_pkg::token_t             tok_a  [DEPTH];
  logic [IDX_W-1:0]            tidx_a [DEPTH];
  logic [pqe_pkg::JOB_W-1:0]   job_a  [DEPTH];
  logic [pqe_pkg::PRIO_W-1:0]  prio_a [DEPTH];

  assign take_req    = start && !busy;
  assign queue_empty = count_q == '0;
  assign queue_full  = count_q == CNT_W'(DEPTH);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pqe_pkg::ST_IDLE: begin
        if (take_req && (kind_i == pqe_pkg::KIND_EXTRACT) && !queue_empty) begin
          state_d = pqe_pkg::ST_SEARCH;
        end
      end
      pqe_pkg::ST_SEARCH: begin
        if (tok_a[DEPTH-1].vld) begin
          state_d = pqe_pkg::ST_IDLE;
        end
      end
      default: state_d = pqe_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    busy   = 1'b0;
    launch = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      pqe_pkg::ST_IDLE: begin
        launch = take_req && (kind_i == pqe_pkg::KIND_EXTRACT) && !queue_empty;
      end
      pqe_pkg::ST_SEARCH: begin
        busy   = 1'b1;
        finish = tok_a[DEPTH-1].vld;
      end
      default: busy = 1'b0;
    endcase
  end

  assign ins_en = take_req && (kind_i == pqe_pkg::KIND_INSERT) && !queue_full;

  assign launch_tok.vld  = launch;
  assign launch_tok.hit  = 1'b0;
  assign launch_tok.prio = '0;
  assign launch_tok.job  = '0;

  // Result and count update. Every request gives exactly one result: the quick
  // operations straight away, a real extract once the token has left the row.
  always_comb begin
    count_d = count_q;
    done_d  = 1'b0;
    job_d   = '0;
    found_d = 1'b0;
    acc_d   = 1'b0;
    if (finish) begin
      done_d  = 1'b1;
      job_d   = tok_a[DEPTH-1].job;
      found_d = 1'b1;
      count_d = count_q - CNT_W'(1);
    end else if (take_req) begin
      unique case (kind_i)
        pqe_pkg::KIND_INSERT: begin
          done_d = 1'b1;
          if (!queue_full) begin
            acc_d   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        pqe_pkg::KIND_EXTRACT: begin
          // A non-empty queue reports when its search finishes.
          done_d = queue_empty;
        end
        pqe_pkg::KIND_CLEAR: begin
          done_d  = 1'b1;
          count_d = '0;
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqe_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    found_q <= found_d;
    acc_q   <= acc_d;
  end

  // The row of cells; the last cell has no right neighbour and keeps its entry,
  // which lies beyond the count after a removal.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pqe_pkg::token_t             tok_in;
    logic [IDX_W-1:0]            idx_in;
    logic [pqe_pkg::JOB_W-1:0]   nxt_job;
    logic [pqe_pkg::PRIO_W-1:0]  nxt_prio;

    if (i == 0) begin : g_head
      assign tok_in = launch_tok;
      assign idx_in = '0;
    end else begin : g_body
      assign tok_in = tok_a[i-1];
      assign idx_in = tidx_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nxt_job  = job_a[i];
      assign nxt_prio = prio_a[i];
    end else begin : g_link
      assign nxt_job  = job_a[i+1];
      assign nxt_prio = prio_a[i+1];
    end

    pqe_cell #(
      .DEPTH    (DEPTH),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .ins_i      (ins_en),
      .ins_job_i  (job_id_i),
      .ins_prio_i (priority_req_i),
      .shift_i    (finish),
      .best_idx_i (tidx_a[DEPTH-1]),
      .nxt_job_i  (nxt_job),
      .nxt_prio_i (nxt_prio),
      .tok_i      (tok_in),
      .tok_idx_i  (idx_in),
      .tok_o      (tok_a[i]),
      .tok_idx_o  (tidx_a[i]),
      .job_o      (job_a[i]),
      .prio_o     (prio_a[i])
    );
  end

  // The status fields follow the count, which holds still while a result shows.
  assign done_o     = done_q;
  assign job_out_o  = job_q;
  assign found_o    = found_q;
  assign accepted_o = acc_q;
  assign count_o    = pqe_pkg::COUNT_W'(count_q);
  assign is_full_o  = queue_full;
  assign is_empty_o = queue_empty;

endmodule

// File: sv/pqe_checker.sv
`include "assert_macros.svh"

module pqe_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         found_o,
  input logic                         accepted_o,
  input logic                         is_full_o,
  input logic                         is_empty_o
);

  // A taken request either reports at once or keeps the block busy searching.
  `PQE_ASSERT(a_req_progress, (start && !busy) |=> (busy || done_o), "request lost")
  // A result only follows a taken request or the end of a search.
  `PQE_ASSERT(a_done_cause, done_o |-> $past(busy || start), "result without a request")
  // One request cannot both store and remove an entry.
  `PQE_ASSERT(a_found_xor_acc, done_o |-> !(found_o && accepted_o), "found and accepted")
  // A removal leaves room, and a store leaves something held.
  `PQE_ASSERT(a_status, done_o |-> !(found_o && is_full_o) && !(accepted_o && is_empty_o),
              "status disagrees with result")
  // The queue is never reported full and empty together.
  `PQE_ASSERT_ALWAYS(a_full_empty, !(is_full_o && is_empty_o), "full and empty")

endmodule

bind priority_queue_extract_max pqe_checker u_pqe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .found_o    (found_o),
  .accepted_o (accepted_o),
  .is_full_o  (is_full_o),
  .is_empty_o (is_empty_o)
);

// File: test/tb_top.sv
module tb_top;

  // The queue depth under test, and the code that no operation uses.
  localparam int          QUEUE_DEPTH  = 16;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          RANDOM_ITEMS = 1225;

  // One reply of the queue, with the same fields as the result ports.
  typedef struct packed {
    logic [pqe_pkg::JOB_W-1:0]   job;
    logic                        found;
    logic                        accepted;
    logic [pqe_pkg::COUNT_W-1:0] count;
    logic                        is_full;
    logic                        is_empty;
  } queue_reply_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [1:0]                   kind;
  logic [pqe_pkg::JOB_W-1:0]    job_id;
  logic [pqe_pkg::PRIO_W-1:0]   priority_req;
  logic                         done;
  logic [pqe_pkg::JOB_W-1:0]    job_out;
  logic                         found;
  logic                         accepted;
  logic [pqe_pkg::COUNT_W-1:0]  count;
  logic                         is_full;
  logic                         is_empty;

  // Our own copy of the queue contents, kept in arrival order.
  logic [pqe_pkg::JOB_W-1:0]    held_jobs  [QUEUE_DEPTH];
  logic [pqe_pkg::PRIO_W-1:0]   held_prios [QUEUE_DEPTH];
  int                           held_count;

  // Replies that accepted requests have yet to produce, oldest first.
  queue_reply_t                 pending_replies [$];
  int                           failure_count;
  int                           cycle_count;
  bit                           steady_flow;

  priority_queue_extract_max #(
    .DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind),
    .job_id_i       (job_id),
    .priority_req_i (priority_req),
    .done_o         (done),
    .job_out_o      (job_out),
    .found_o        (found),
    .accepted_o     (accepted),
    .count_o        (count),
    .is_full_o      (is_full),
    .is_empty_o     (is_empty)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Applies one request to our copy of the queue and returns the reply that
  // the block must give for it. An extract picks the first entry holding the
  // largest priority, so a later entry only wins with a strictly larger one.
  function automatic queue_reply_t serve_request(logic [1:0] op,
                                                 logic [pqe_pkg::JOB_W-1:0] job,
                                                 logic [pqe_pkg::PRIO_W-1:0] prio);
    queue_reply_t reply;
    int           best;
    reply = '0;
    case (op)
      pqe_pkg::KIND_INSERT: begin
        if (held_count < QUEUE_DEPTH) begin
          held_jobs[held_count]  = job;
          held_prios[held_count] = prio;
          held_count++;
          reply.accepted = 1'b1;
        end
      end
      pqe_pkg::KIND_EXTRACT: begin
        if (held_count > 0) begin
          best = 0;
          for (int i = 1; i < held_count; i++) begin
            if (held_prios[i] > held_prios[best]) begin
              best = i;
            end
          end
          reply.job   = held_jobs[best];
          reply.found = 1'b1;
          // The entries behind the removed one close the gap.
          for (int i = best; i + 1 < held_count; i++) begin
            held_jobs[i]  = held_jobs[i + 1];
            held_prios[i] = held_prios[i + 1];
          end
          held_count--;
        end
      end
      pqe_pkg::KIND_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    reply.count    = pqe_pkg::COUNT_W'(held_count);
    reply.is_full  = (held_count == QUEUE_DEPTH);
    reply.is_empty = (held_count == 0);
    return reply;
  endfunction

  // Presents one request after a random pause and holds it until the block
  // takes it. Inputs move on the falling edge; the handshake is judged on the
  // rising edge, where busy still shows its value from before the edge. With
  // no pause start simply stays high, so it is assigned once per edge only.
  task automatic send_request(logic [1:0] op, logic [pqe_pkg::JOB_W-1:0] job,
                              logic [pqe_pkg::PRIO_W-1:0] prio);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    kind         <= op;
    job_id       <= job;
    priority_req <= prio;
    do begin
      @(posedge clk_i);
    end while (busy);
    pending_replies.push_back(serve_request(op, job, prio));
  endtask

  // Every reply is compared with the oldest expectation. A reply with nothing
  // waiting for it counts as a failure as well.
  always @(posedge clk_i) begin
    queue_reply_t seen;
    queue_reply_t wanted;
    if (rst_ni && done) begin
      seen = '{job_out, found, accepted, count, is_full, is_empty};
      if (pending_replies.size() == 0) begin
        failure_count++;
        if (failure_count <= 10) begin
          $display("Unexpected reply at cycle %0d: job %h found %b accepted %b count %0d",
                   cycle_count, job_out, found, accepted, count);
        end
      end else begin
        wanted = pending_replies.pop_front();
        if (seen !== wanted) begin
          failure_count++;
          if (failure_count <= 10) begin
            $display(
              "Mismatch at cycle %0d: expected job %h found %b acc %b count %0d full %b empty %b",
              cycle_count, wanted.job, wanted.found, wanted.accepted, wanted.count,
              wanted.is_full, wanted.is_empty);
            $display("  actual: job %h found %b acc %b count %0d full %b empty %b",
                     job_out, found, accepted, count, is_full, is_empty);
          end
        end
      end
    end
  end

  // Watchdog: a run that hangs on a handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // An empty queue: an extract finds nothing, a clear and an unused code
  // leave it empty. The unused code carries all-ones fields.
  task automatic test_empty_queue();
    send_request(pqe_pkg::KIND_EXTRACT, 16'hFFFF, 8'hFF);
    send_request(pqe_pkg::KIND_CLEAR, 16'h0000, 8'h00);
    send_request(KIND_UNUSED, 16'hFFFF, 8'hFF);
  endtask

  // Fill the queue to the brim with extreme ids and priorities, many of them
  // equal, then push one more request that must be dropped.
  task automatic test_fill_and_overflow();
    logic [pqe_pkg::PRIO_W-1:0] prio;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0) begin
        prio = 8'h00;
      end else if (i == 1 || i == 5) begin
        prio = 8'hFF;
      end else begin
        prio = (i % 3 != 0) ? 8'h80 : 8'h07;
      end
      send_request(pqe_pkg::KIND_INSERT, (i == 1) ? 16'hFFFF : pqe_pkg::JOB_W'(i), prio);
    end
    send_request(pqe_pkg::KIND_INSERT, 16'hAAAA, 8'hFF);
  endtask

  // Ties: the earliest of equal priorities leaves first, and the rest close up.
  // A clear then empties the rest of the queue in one go.
  task automatic test_tie_order();
    repeat (3) send_request(pqe_pkg::KIND_EXTRACT, 16'h0000, 8'h00);
    send_request(pqe_pkg::KIND_CLEAR, 16'h5555, 8'h55);
  endtask

  // Random traffic in phases. Most phases lean towards filling or draining so
  // that the queue really reaches full and empty; clears and the unused code
  // are scattered in as noise. Narrow priority ranges make ties common.
  task automatic test_random_traffic(int n_items);
    int                         sent;
    int                         phase_left;
    int                         lean;
    int                         prio_mode;
    int                         pick;
    logic [1:0]                 op;
    logic [pqe_pkg::PRIO_W-1:0] prio;
    sent       = 0;
    phase_left = 0;
    lean       = 0;
    prio_mode  = 0;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        phase_left  = $urandom_range(8, 40);
        lean        = $urandom_range(0, 2);
        prio_mode   = $urandom_range(0, 2);
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        op = pqe_pkg::KIND_CLEAR;
      end else if (pick < 4) begin
        op = KIND_UNUSED;
      end else if (lean == 0) begin
        op = (pick < 80) ? pqe_pkg::KIND_INSERT : pqe_pkg::KIND_EXTRACT;
      end else if (lean == 1) begin
        op = (pick < 24) ? pqe_pkg::KIND_INSERT : pqe_pkg::KIND_EXTRACT;
      end else begin
        op = (pick < 52) ? pqe_pkg::KIND_INSERT : pqe_pkg::KIND_EXTRACT;
      end
      case (prio_mode)
        0:       prio = pqe_pkg::PRIO_W'($urandom_range(0, 3));
        1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: prio = pqe_pkg::PRIO_W'($urandom_range(0, 255));
      endcase
      send_request(op, pqe_pkg::JOB_W'($urandom_range(0, 65535)), prio);
      phase_left--;
      sent++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    start        <= 1'b0;
    kind         <= pqe_pkg::KIND_INSERT;
    job_id       <= '0;
    priority_req <= '0;
    held_count    = 0;
    failure_count = 0;
    cycle_count  <= 0;
    steady_flow   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_fill_and_overflow();
    test_tie_order();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk_i);
    start <= 1'b0;
    // Wait for the last reply, then long enough for a stray one to show up.
    wait (pending_replies.size() == 0);
    repeat (QUEUE_DEPTH + 4) @(posedge clk_i);

    if (failure_count == 0 && pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
